FILE: rtl/prz_pkg.sv
// ============================================================================
// prz_pkg
// Shared types and constants for the point rotate / project / depth-test unit.
// ============================================================================
package prz_pkg;

    localparam logic [1:0] OP_PLOT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] REG_SIN_A  = 3'd0;
    localparam logic [2:0] REG_COS_A  = 3'd1;
    localparam logic [2:0] REG_SIN_B  = 3'd2;
    localparam logic [2:0] REG_COS_B  = 3'd3;
    localparam logic [2:0] REG_SIN_C  = 3'd4;
    localparam logic [2:0] REG_COS_C  = 3'd5;
    localparam logic [2:0] REG_FOCAL  = 3'd6;
    localparam logic [2:0] REG_CAMERA = 3'd7;

    localparam logic [7:0]  BLANK_GLYPH = 8'd32;
    localparam logic [16:0] RECIP_MAX   = 17'd65535;

    // plot request handed from the geometry pipe to the buffer stage
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [15:0] recip;
    } t_plot;

endpackage

FILE: rtl/prz_ram.sv
// ============================================================================
// prz_ram
// Generic single-port RAM with registered read.
// ============================================================================
module prz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/prz_recip.sv
// ============================================================================
// prz_recip
// Radix-2 restoring divider: floor(2^34 / z), saturated to 16 bits.
// One quotient bit per cycle; a 35-bit quotient per divide.
// ============================================================================
module prz_recip
    import prz_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_den,
    output logic        o_done,
    output logic [15:0] o_recip
);
    logic [30:0] r_rem, n_rem;
    logic [34:0] r_quo, n_quo;
    logic [29:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [30:0] w_try;
    logic [30:0] w_sub;

    // shift in one dividend bit (only the top bit of 2^34 is set)
    always_comb begin
        w_try = {r_rem[29:0], (r_cnt == 6'd34)};
        w_sub = w_try - {1'b0, r_den};
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_sub;
            n_quo = {r_quo[33:0], 1'b1};
        end else begin
            n_rem = w_try;
            n_quo = {r_quo[33:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd34;
                r_rem  <= '0;
                r_quo  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_recip = (r_quo > {18'd0, RECIP_MAX}) ? 16'hFFFF : r_quo[15:0];
endmodule

FILE: rtl/point_rotate_project_zbuffer_unit.sv
// ============================================================================
// point_rotate_project_zbuffer_unit
// Rotates a point, projects it and depth-tests it against a cell buffer.
// ============================================================================
//  channel   | signals                                   | direction
//  command   | i_start, o_busy, i_operation .. i_cell_*  | in
//  result    | o_valid, o_in_view, o_drawn, o_cell_glyph | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data| in
//
//  Plot: transfer cycle, 2 matrix steps, 1 depth check, the 35-step
//  divide, 2 projection steps, 1 buffer read, 1 write/result. A point
//  at or behind the camera ends after the depth check. Read and clear
//  go from the transfer to the cell step. After reset a clearing pass
//  writes every cell, busy high throughout. Results are one-cycle strobes.
module point_rotate_project_zbuffer_unit
    import prz_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic signed [11:0] i_coord_i,
    input  logic signed [11:0] i_coord_j,
    input  logic signed [11:0] i_coord_k,
    input  logic [7:0]         i_glyph,
    input  logic [12:0]        i_cell_address,
    output logic               o_valid,
    output logic               o_in_view,
    output logic               o_drawn,
    output logic [7:0]         o_cell_glyph,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW:0] CELLS_L = AW'(CELLS - 1) + (AW+1)'(1);

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_MAT1 = 11'b00000000100,
        S_MAT2 = 11'b00000001000,
        S_ROT  = 11'b00000010000,
        S_DIV  = 11'b00000100000,
        S_PRJ1 = 11'b00001000000,
        S_PRJ2 = 11'b00010000000,
        S_RD   = 11'b00100000000,
        S_WB   = 11'b01000000000,
        S_CELL = 11'b10000000000
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [17:0] r_sa, r_ca, r_sb, r_cb, r_sc, r_cc;
    logic [7:0]  r_focal;
    logic [9:0]  r_cam;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0; r_ca <= 18'sd16384;
            r_sb <= '0; r_cb <= 18'sd16384;
            r_sc <= '0; r_cc <= 18'sd16384;
            r_focal <= 8'd40;
            r_cam   <= 10'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIN_A:  r_sa <= 18'($signed(i_cfg_data));
                REG_COS_A:  r_ca <= 18'($signed(i_cfg_data));
                REG_SIN_B:  r_sb <= 18'($signed(i_cfg_data));
                REG_COS_B:  r_cb <= 18'($signed(i_cfg_data));
                REG_SIN_C:  r_sc <= 18'($signed(i_cfg_data));
                REG_COS_C:  r_cc <= 18'($signed(i_cfg_data));
                REG_FOCAL:  r_focal <= i_cfg_data[7:0];
                REG_CAMERA: r_cam <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // product of two Q4.14 values with floor
    function automatic logic signed [17:0] m14(input logic signed [17:0] a,
                                               input logic signed [17:0] b);
        logic signed [35:0] p;
        p = a * b;
        return p[31:14];
    endfunction

    // item registers
    logic [1:0]  r_op;
    logic signed [11:0] r_ci, r_cj, r_ck;
    logic [7:0]  r_glyph;
    logic [12:0] r_addr;

    // matrix entries
    logic signed [17:0] r_sasb, r_casb, r_cbcc, r_cbsc, r_sacb, r_cacb;
    logic signed [17:0] r_sasc, r_casc, r_cacc, r_sacc;
    logic signed [18:0] r_mxi, r_mxj, r_mxk, r_myi, r_myj, r_myk, r_mzj, r_mzk;
    logic signed [33:0] r_xr, r_yr, r_zr;
    logic signed [56:0] r_kx, r_ky;
    logic [23:0] r_k;
    logic [15:0] r_recip;
    logic signed [24:0] r_col, r_row;
    logic [AW-1:0] w_cell;
    logic          r_hit;

    assign w_cell = AW'(r_col + r_row * 25'(SCREEN_WIDTH));

    // divider
    logic        w_div_start, w_div_done;
    logic [15:0] w_recip;
    prz_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (r_zr[29:0]),
        .o_done  (w_div_done),
        .o_recip (w_recip)
    );

    // memories
    logic          w_we;
    logic [AW-1:0] w_maddr;
    logic [15:0]   w_wdepth, w_rdepth;
    logic [7:0]    w_wglyph, w_rglyph;
    logic [AW:0]   r_clr;

    prz_ram #(.WIDTH(16), .DEPTH(CELLS)) u_depth (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_maddr),
        .i_wdata(w_wdepth), .o_rdata(w_rdepth));
    prz_ram #(.WIDTH(8), .DEPTH(CELLS)) u_glyph (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_maddr),
        .i_wdata(w_wglyph), .o_rdata(w_rglyph));

    logic w_addr_ok;
    assign w_addr_ok = ({19'd0, r_addr} < 32'(CELLS));

    t_plot w_plot;
    assign w_plot.valid = (r_state == S_WB);
    assign w_plot.hit   = r_hit;
    assign w_plot.recip = r_recip;

    // memory port: clearing pass, plot write-back, cell op, otherwise read
    always_comb begin
        w_we     = 1'b0;
        w_maddr  = w_cell;
        w_wdepth = '0;
        w_wglyph = BLANK_GLYPH;
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_maddr = r_clr[AW-1:0];
        end else if (w_plot.valid) begin
            w_we     = w_plot.hit && (w_plot.recip > w_rdepth);
            w_wdepth = w_plot.recip;
            w_wglyph = r_glyph;
        end else if (r_state == S_IDLE) begin
            // read the addressed cell on the transfer edge
            w_maddr = AW'(i_cell_address);
        end else if (r_state == S_CELL) begin
            w_maddr = AW'(r_addr);
            w_we    = (r_op == OP_CLEAR) && w_addr_ok;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    logic signed [33:0] w_z;
    assign w_z = r_zr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CELLS_L - 1'b1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_op <= i_operation;
                        r_ci <= i_coord_i; r_cj <= i_coord_j; r_ck <= i_coord_k;
                        r_glyph <= i_glyph;
                        r_addr  <= i_cell_address;
                        r_state <= (i_operation == OP_PLOT) ? S_MAT1 : S_CELL;
                        r_sasb <= m14(r_sa, r_sb); r_casb <= m14(r_ca, r_sb);
                        r_cbcc <= m14(r_cb, r_cc); r_cbsc <= m14(r_cb, r_sc);
                        r_sacb <= m14(r_sa, r_cb); r_cacb <= m14(r_ca, r_cb);
                        r_sasc <= m14(r_sa, r_sc); r_casc <= m14(r_ca, r_sc);
                        r_cacc <= m14(r_ca, r_cc); r_sacc <= m14(r_sa, r_cc);
                    end
                end
                S_MAT1: begin
                    r_mxi <= 19'(r_cbcc);
                    r_mxj <= 19'(m14(r_sasb, r_cc)) + 19'(r_casc);
                    r_mxk <= 19'(r_sasc) - 19'(m14(r_casb, r_cc));
                    r_myi <= -19'(r_cbsc);
                    r_myj <= 19'(r_cacc) - 19'(m14(r_sasb, r_sc));
                    r_myk <= 19'(r_sacc) + 19'(m14(r_casb, r_sc));
                    r_mzj <= -19'(r_sacb);
                    r_mzk <= 19'(r_cacb);
                    r_state <= S_MAT2;
                end
                S_MAT2: begin
                    r_xr <= 34'(r_ci * r_mxi) + 34'(r_cj * r_mxj) + 34'(r_ck * r_mxk);
                    r_yr <= 34'(r_ci * r_myi) + 34'(r_cj * r_myj) + 34'(r_ck * r_myk);
                    r_zr <= 34'(r_ci * r_sb) + 34'(r_cj * r_mzj)
                          + 34'(r_ck * r_mzk) + 34'({r_cam, 18'd0});
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (w_z > 0) begin
                        r_state <= S_DIV;
                    end else begin
                        o_valid <= 1'b1;
                        o_in_view <= 1'b0; o_drawn <= 1'b0; o_cell_glyph <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_recip <= w_recip;
                        r_k     <= r_focal * w_recip;
                        r_state <= S_PRJ1;
                    end
                end
                S_PRJ1: begin
                    // rotated x and y fit 32 bits signed
                    r_kx <= 57'($signed(r_xr[31:0]) * $signed({1'b0, r_k}));
                    r_ky <= 57'($signed(r_yr[31:0]) * $signed({1'b0, r_k}));
                    r_state <= S_PRJ2;
                end
                S_PRJ2: begin
                    // x: >>33, y: >>34, floor on the full product
                    r_col <= 25'(SCREEN_WIDTH / 2) + 25'(r_kx >>> 33);
                    r_row <= 25'(SCREEN_HEIGHT / 2) + 25'(r_ky >>> 34);
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_hit <= (r_col >= 0) && (r_col < 25'(SCREEN_WIDTH))
                          && (r_row >= 0) && (r_row < 25'(SCREEN_HEIGHT));
                    r_state <= S_WB;
                end
                S_WB: begin
                    o_valid <= 1'b1;
                    o_in_view <= r_hit;
                    o_drawn <= r_hit && (r_recip > w_rdepth);
                    o_cell_glyph <= '0;
                    r_state <= S_IDLE;
                end
                S_CELL: begin
                    o_valid <= 1'b1;
                    o_in_view <= 1'b0; o_drawn <= 1'b0;
                    o_cell_glyph <= (r_op == OP_READ)
                                  ? (w_addr_ok ? w_rglyph : BLANK_GLYPH) : 8'd0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_div_start = (r_state == S_ROT) && (w_z > 0);
endmodule

FILE: rtl/prz_checker.sv
// ============================================================================
// prz_checker
// Port-level checks for the point rotate / project / depth-test unit.
// ============================================================================
module prz_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic       o_in_view,
    input logic       o_drawn,
    input logic [7:0] o_cell_glyph
);
    // a result strobe lasts one cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result strobe");

    // drawn implies in view
    a_drawn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drawn |-> o_in_view) else $error("drawn outside view");

    // plot results carry no glyph
    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_view |-> o_cell_glyph == 8'd0) else $error("glyph on plot");

    // a transfer makes the unit busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("start not taken");
endmodule

bind point_rotate_project_zbuffer_unit prz_checker u_prz_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_valid(o_valid), .o_in_view(o_in_view), .o_drawn(o_drawn),
    .o_cell_glyph(o_cell_glyph)
);
